// ----- rtl/wsd_pkg.sv -----
// Package for the work-stealing deque: operation and status codes,
// and the request and response beat types. No dependencies.
`timescale 1ns / 1ps

package wsd_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_STEAL = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] push_value;
  } req_beat_t;

  typedef struct packed {
    logic [31:0] out_value;
    logic        got_item;
    status_t     status;
    logic        now_empty;
  } rsp_beat_t;

endpackage

// ----- rtl/wsd_store.sv -----
// Entry store of the deque: one write port and one registered read port.
// Standalone; instantiated by work_stealing_deque.
`timescale 1ns / 1ps

module wsd_store #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the last read while no new read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/work_stealing_deque.sv -----
// Work-stealing deque top level: top/bottom indices, entry store, response stage.
// Depends on wsd_pkg and wsd_store.
// Each response is registered in the response stage behind the s1 stage.
// Throughput: one beat per cycle unless a response stall holds the s1 stage; each
// beat writes or reads the store once at most; the registered read pairs with s1.
// Reset clears both indices and all valid flags; the entry store is not cleared.
`timescale 1ns / 1ps

module work_stealing_deque #(
  parameter int LOG_DEPTH   = 10,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  wsd_pkg::req_beat_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output wsd_pkg::rsp_beat_t rsp
);

  localparam int DEPTH = 1 << LOG_DEPTH;
  localparam int IW    = LOG_DEPTH + 1;

  logic [IW-1:0] top, top_next;
  logic [IW-1:0] bottom, bottom_next;
  logic [IW-1:0] occ, last;
  logic          full, empty, accept;

  logic                   mem_we, mem_re;
  logic [LOG_DEPTH-1:0]   mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;
  logic [63:0]            push_wide, read_wide;

  logic                 take_c, now_empty_c;
  wsd_pkg::status_t     status_c;

  logic                 s1_valid, s1_got, s1_now_empty, s1_adv;
  wsd_pkg::status_t     s1_status;

  assign occ    = bottom - top;
  assign last   = bottom - IW'(1);
  assign full   = (occ == IW'(DEPTH - 1));
  assign empty  = (occ == '0);
  assign accept = req_valid && !req_stall;

  assign push_wide = {32'd0, req.push_value};
  assign mem_wdata = push_wide[VALUE_WIDTH-1:0];
  assign read_wide = 64'(mem_rdata);

  always_comb begin
    top_next    = top;
    bottom_next = bottom;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = bottom[LOG_DEPTH-1:0];
    mem_raddr   = top[LOG_DEPTH-1:0];
    take_c      = 1'b0;
    status_c    = wsd_pkg::ST_OK;
    case (req.op)
      wsd_pkg::OP_PUSH: begin
        if (full) begin
          status_c = wsd_pkg::ST_FULL;
        end else begin
          mem_we      = accept;
          bottom_next = bottom + IW'(1);
        end
      end
      wsd_pkg::OP_POP: begin
        if (empty) begin
          status_c = wsd_pkg::ST_EMPTY;
        end else begin
          mem_re    = accept;
          mem_raddr = last[LOG_DEPTH-1:0];
          take_c    = 1'b1;
          // last entry: consume as a steal, indices meet at bottom
          if (occ == IW'(1)) begin
            top_next = top + IW'(1);
          end else begin
            bottom_next = last;
          end
        end
      end
      wsd_pkg::OP_STEAL: begin
        if (empty) begin
          status_c = wsd_pkg::ST_EMPTY;
        end else begin
          mem_re   = accept;
          take_c   = 1'b1;
          top_next = top + IW'(1);
        end
      end
      default: begin
      end
    endcase
    now_empty_c = (bottom_next == top_next);
  end

  wsd_store #(
    .ADDR_W (LOG_DEPTH),
    .DATA_W (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top    <= '0;
      bottom <= '0;
    end else if (accept) begin
      top    <= top_next;
      bottom <= bottom_next;
    end
  end

  assign s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_got       <= take_c;
      s1_status    <= status_c;
      s1_now_empty <= now_empty_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.out_value <= s1_got ? read_wide[31:0] : 32'd0;
      rsp.got_item  <= s1_got;
      rsp.status    <= s1_status;
      rsp.now_empty <= s1_now_empty;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= IW'(DEPTH - 1))
    else $error("occupancy beyond capacity");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && take_c |=> occ == $past(occ) - IW'(1))
    else $error("removal did not shrink the deque by one");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && mem_we |=> occ == $past(occ) + IW'(1))
    else $error("push did not grow the deque by one");

  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("request stalled with a free pipeline");

  a_take_ok: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_got |-> s1_status == wsd_pkg::ST_OK && !s1_now_empty || s1_got &&
      s1_status == wsd_pkg::ST_OK)
    else $error("removed entry with non-ok status");
`endif

endmodule

// ----- dv/work_stealing_deque_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for work_stealing_deque: directed table, fill to capacity under a long
// output hold-off, drain, then random traffic, all scored against a shadow deque.
// Depends on wsd_pkg and the work_stealing_deque RTL.

module work_stealing_deque_test;

  localparam int LOG_DEPTH    = 10;
  localparam int DEPTH        = 1 << LOG_DEPTH;
  localparam int IDX_W        = LOG_DEPTH + 1;
  localparam int NUM_DIR      = 22;
  localparam int RANDOM_BEATS = 850;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int PRINT_CAP    = 50;

  typedef struct packed {
    wsd_pkg::op_t       op;
    logic [31:0]        val;
    logic               typed;
    wsd_pkg::rsp_beat_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  wsd_pkg::req_beat_t req = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  wsd_pkg::rsp_beat_t rsp;

  logic [31:0]      shadow_slots [DEPTH];
  logic [IDX_W-1:0] shadow_top = '0;
  logic [IDX_W-1:0] shadow_bottom = '0;

  wsd_pkg::rsp_beat_t expected_rsp [$];
  int  errors = 0;
  int  beats_sent = 0;
  int  full_refusals = 0;
  int  empty_removals = 0;
  int  entries_returned = 0;
  int  idle_cycles = 0;
  bit  hold_pending = 0;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{wsd_pkg::OP_QUERY, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, wsd_pkg::ST_OK, 1'b1}},
    '{wsd_pkg::OP_POP,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, wsd_pkg::ST_EMPTY, 1'b1}},
    '{wsd_pkg::OP_STEAL, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, wsd_pkg::ST_EMPTY, 1'b1}},
    '{wsd_pkg::OP_PUSH,  32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, wsd_pkg::ST_OK, 1'b0}},
    '{wsd_pkg::OP_POP,   32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, wsd_pkg::ST_OK, 1'b1}},
    '{wsd_pkg::OP_PUSH,  32'h0000_0000, 1'b1, '{32'h0, 1'b0, wsd_pkg::ST_OK, 1'b0}},
    '{wsd_pkg::OP_STEAL, 32'h0000_0000, 1'b1, '{32'h0, 1'b1, wsd_pkg::ST_OK, 1'b1}},
    '{wsd_pkg::OP_PUSH,  32'hA5A5_5A5A, 1'b0, '0},
    '{wsd_pkg::OP_PUSH,  32'h0000_0001, 1'b0, '0},
    '{wsd_pkg::OP_PUSH,  32'h8000_0000, 1'b0, '0},
    '{wsd_pkg::OP_QUERY, 32'hFFFF_FFFF, 1'b0, '0},
    '{wsd_pkg::OP_STEAL, 32'h0000_0000, 1'b0, '0},
    '{wsd_pkg::OP_POP,   32'hFFFF_FFFF, 1'b0, '0},
    '{wsd_pkg::OP_POP,   32'h0000_0000, 1'b0, '0},
    '{wsd_pkg::OP_POP,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, wsd_pkg::ST_EMPTY, 1'b1}},
    '{wsd_pkg::OP_PUSH,  32'h1234_5678, 1'b0, '0},
    '{wsd_pkg::OP_PUSH,  32'hFEDC_BA98, 1'b0, '0},
    '{wsd_pkg::OP_QUERY, 32'h0000_0000, 1'b0, '0},
    '{wsd_pkg::OP_STEAL, 32'h0000_0000, 1'b0, '0},
    '{wsd_pkg::OP_STEAL, 32'h0000_0000, 1'b0, '0},
    '{wsd_pkg::OP_STEAL, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, wsd_pkg::ST_EMPTY, 1'b1}},
    '{wsd_pkg::OP_QUERY, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, wsd_pkg::ST_OK, 1'b1}}
  };

  work_stealing_deque #(
    .LOG_DEPTH  (LOG_DEPTH),
    .VALUE_WIDTH(32)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #2 clk = ~clk;

  function automatic wsd_pkg::rsp_beat_t deque_step(input wsd_pkg::req_beat_t b);
    wsd_pkg::rsp_beat_t r;
    logic [IDX_W-1:0]   fill;
    logic [IDX_W-1:0]   last;
    r = '0;
    r.status = wsd_pkg::ST_OK;
    fill = shadow_bottom - shadow_top;
    last = shadow_bottom - 1'b1;
    case (b.op)
      wsd_pkg::OP_PUSH: begin
        if (fill >= IDX_W'(DEPTH - 1)) begin
          r.status = wsd_pkg::ST_FULL;
        end else begin
          shadow_slots[shadow_bottom[LOG_DEPTH-1:0]] = b.push_value;
          shadow_bottom = shadow_bottom + 1'b1;
        end
      end
      wsd_pkg::OP_POP: begin
        if (fill == '0) begin
          r.status = wsd_pkg::ST_EMPTY;
        end else begin
          r.out_value = shadow_slots[last[LOG_DEPTH-1:0]];
          r.got_item = 1'b1;
          if (fill == IDX_W'(1)) begin
            shadow_top = shadow_top + 1'b1;
            shadow_bottom = shadow_top;
          end else begin
            shadow_bottom = last;
          end
        end
      end
      wsd_pkg::OP_STEAL: begin
        if (fill == '0) begin
          r.status = wsd_pkg::ST_EMPTY;
        end else begin
          r.out_value = shadow_slots[shadow_top[LOG_DEPTH-1:0]];
          r.got_item = 1'b1;
          shadow_top = shadow_top + 1'b1;
        end
      end
      default: ;
    endcase
    r.now_empty = (shadow_bottom == shadow_top);
    return r;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic wsd_pkg::op_t pick_op(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return wsd_pkg::OP_PUSH;
    case ($urandom_range(0, 9))
      0: return wsd_pkg::OP_QUERY;
      1, 2, 3, 4: return wsd_pkg::OP_POP;
      default: return wsd_pkg::OP_STEAL;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Call at a rising edge; returns at a rising edge with the next beat free to go.
  task automatic send_beat(input wsd_pkg::op_t op, input logic [31:0] val, input bit typed,
                           input wsd_pkg::rsp_beat_t want, input bit quiet);
    wsd_pkg::req_beat_t b;
    wsd_pkg::rsp_beat_t predicted;
    int                 gap;
    b.op = op;
    b.push_value = val;
    req_valid <= 1'b1;
    req <= b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = deque_step(b);
    expected_rsp.push_back(typed ? want : predicted);
    beats_sent++;
    if (predicted.status == wsd_pkg::ST_FULL) full_refusals++;
    if (predicted.status == wsd_pkg::ST_EMPTY) empty_removals++;
    if (predicted.got_item) entries_returned++;
    gap = pick_gap(quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Score each response beat against the oldest expectation.
  always @(posedge clk) begin
    wsd_pkg::rsp_beat_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("response beat with nothing pending");
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.out_value !== want.out_value)
          report_mismatch($sformatf("out_value %h, want %h", rsp.out_value, want.out_value));
        if (rsp.got_item !== want.got_item)
          report_mismatch($sformatf("got_item %b, want %b", rsp.got_item, want.got_item));
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
        if (rsp.now_empty !== want.now_empty)
          report_mismatch($sformatf("now_empty %b, want %b", rsp.now_empty, want.now_empty));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Response side: random stall pattern, plus one long hold-off on request.
  initial begin
    int  r;
    bit  stalled;
    int  len;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 0;
        stalled = 1'b1;
        len = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          stalled = 1'b0;
          len = $urandom_range(1, 8);
        end else if (r < 60) begin
          stalled = 1'b0;
          len = $urandom_range(30, 80);
        end else if (r < 90) begin
          stalled = 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 98) begin
          stalled = 1'b1;
          len = $urandom_range(4, 10);
        end else begin
          stalled = 1'b1;
          len = $urandom_range(20, 60);
        end
      end
      rsp_stall <= stalled;
      repeat (len) @(posedge clk);
    end
  end

  initial begin
    wsd_pkg::rsp_beat_t none;
    int                 done_beats;
    int                 seg_len;
    int                 push_pct;
    bit                 quiet;
    none = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIR; i++) begin
      send_beat(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want, 1'b0);
    end

    // Fill past capacity back to back while the output is held off.
    hold_pending = 1;
    for (int i = 0; i < DEPTH + 6; i++) begin
      send_beat(wsd_pkg::OP_PUSH, pick_value(), 1'b0, none, 1'b1);
    end
    for (int i = 0; i < 40; i++) begin
      send_beat(pick_op(70), pick_value(), 1'b0, none, 1'b0);
    end

    // Drain from both ends.
    while (shadow_bottom != shadow_top) begin
      send_beat($urandom_range(0, 1) ? wsd_pkg::OP_POP : wsd_pkg::OP_STEAL, pick_value(),
                1'b0, none, $urandom_range(0, 3) == 0);
    end
    send_beat(wsd_pkg::OP_POP, pick_value(), 1'b0, none, 1'b0);
    send_beat(wsd_pkg::OP_STEAL, pick_value(), 1'b0, none, 1'b0);

    done_beats = 0;
    while (done_beats < RANDOM_BEATS) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0: push_pct = 75;
        1: push_pct = 25;
        2: push_pct = 50;
        default: push_pct = 10;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len && done_beats < RANDOM_BEATS; i++) begin
        send_beat(pick_op(push_pct), pick_value(), 1'b0, none, quiet);
        done_beats++;
      end
    end
    req_valid <= 1'b0;

    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d request beats through fill to capacity, drain and random traffic:",
             beats_sent);
    $display("  %0d pushes refused as full, %0d removals on empty, %0d entries returned",
             full_refusals, empty_removals, entries_returned);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
